// ----- rtl/lmps_pkg.sv -----
// Shared types and constants for the LED matrix PWM row scanner.
// No dependencies; imported by every module of the block.
package lmps_pkg;

  localparam int unsigned RowCount = 8;
  localparam int unsigned ColCount = 8;
  localparam int unsigned RowW     = 3;
  localparam int unsigned ColW     = 3;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned LimitW   = 5;
  localparam int unsigned NibW     = 4;
  localparam int unsigned RowBitsW = ColCount * NibW;   // 32
  localparam int unsigned OnBitsW  = 3 * ColCount;      // 24
  localparam int unsigned MapSelW  = 5;

  // Request codes
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqTick  = 1'b1;

  // Level count limits
  localparam logic [LimitW-1:0] LimitMin = 5'd1;
  localparam logic [LimitW-1:0] LimitMax = 5'd16;

  // Driver bit sources: index into the on/off vector, colour c of column n at 3n+c
  // (red 0, green 1, blue 2). NoLed marks driver outputs with nothing attached.
  localparam logic [MapSelW-1:0] NoLed = 5'd31;

  // Entry b sits at [b*5 +: 5]; listed from bit 15 down to bit 0.
  localparam logic [16*MapSelW-1:0] FirstMap = {
    5'd13, 5'd12, 5'd10, 5'd8, 5'd6, 5'd4, 5'd2, 5'd0,
    NoLed, NoLed, NoLed, NoLed, 5'd17, 5'd18, 5'd19, 5'd23
  };
  localparam logic [16*MapSelW-1:0] SecondMap = {
    NoLed, NoLed, NoLed, 5'd9, 5'd7, 5'd5, 5'd3, 5'd1,
    5'd11, 5'd14, 5'd15, 5'd16, 5'd20, 5'd21, 5'd22, NoLed
  };

  typedef struct packed {
    logic             en;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [NibW-1:0]  red;
    logic [NibW-1:0]  green;
    logic [NibW-1:0]  blue;
  } lmps_wr_t;

  function automatic logic [15:0] pack_word(input logic [16*MapSelW-1:0] map,
                                            input logic [OnBitsW-1:0]    on_bits);
    logic [15:0]          w;
    logic [MapSelW-1:0]   src;
    w = '0;
    for (int b = 0; b < 16; b++) begin
      src = map[b*MapSelW +: MapSelW];
      if (src < MapSelW'(OnBitsW)) begin
        w[b] = on_bits[src];
      end
    end
    return w;
  endfunction

endpackage

// ----- rtl/led_matrix_pwm_row_scanner.sv -----
// Top level of the 8x8 RGB LED matrix PWM row scanner.
// Depends on lmps_pkg, lmps_frame_store, lmps_row_encode and lmps_scan_ctrl.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries requests: a pixel write
//   (req_type_i = 0, pixel_index_i = row*8 + column, pixel_color_i = RGB
//   nibbles) or a display tick (req_type_i = 1). A write gives no result.
//   Each tick gives one beat on the output channel (out_valid_o / out_stall_i):
//   the two driver words for the current row at the current PWM level, with
//   row_select_o and pwm_step_o, then the row advances (level on row wrap).
//   cfg_valid_i / cfg_ready_o writes the level count; ready is always high.
//   Throughput: one request per cycle while no tick waits on a held
//   result; the path is input register, row read, 24 nibble compares
//   and a fixed bit permutation, result register.
//   A write is applied to the frame store before any later tick reads it.
//   Receiver stall: the result register holds; a tick waiting behind it
//   holds the input register and raises in_stall_o, while a waiting write
//   still completes. No result is lost or repeated.
//   Reset: frame cleared (dark), row and level zero, level count 16.
module led_matrix_pwm_row_scanner import lmps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [5:0]          pixel_index_i,
  input  logic [11:0]         pixel_color_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         driver_word_first_o,
  output logic [15:0]         driver_word_second_o,
  output logic [RowW-1:0]     row_select_o,
  output logic [LevelW-1:0]   pwm_step_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LimitW-1:0]   cfg_data_i
);

  // input register
  logic        in_valid_q;
  logic        req_q;
  logic [5:0]  index_q;
  logic [11:0] color_q;

  // result register
  logic              out_valid_q;
  logic [15:0]       first_q, second_q;
  logic [RowW-1:0]   row_sel_q;
  logic [LevelW-1:0] step_q;

  logic              out_free, tick_go, wr_go, item_go, in_accept;
  lmps_wr_t          wr;
  logic [RowW-1:0]   scan_row;
  logic [LevelW-1:0] scan_level;
  logic [RowBitsW-1:0] red_row, green_row, blue_row;
  logic [15:0]       first_d, second_d;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign tick_go   = in_valid_q && (req_q == ReqTick) && out_free;
  assign wr_go     = in_valid_q && (req_q == ReqWrite);
  assign item_go   = tick_go || wr_go;
  assign in_stall_o = in_valid_q && !item_go;
  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    wr.en    = wr_go;
    wr.row   = index_q[5:3];
    wr.col   = index_q[2:0];
    wr.red   = color_q[11:8];
    wr.green = color_q[7:4];
    wr.blue  = color_q[3:0];
  end

  lmps_frame_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_row_i (scan_row),
    .red_o    (red_row),
    .green_o  (green_row),
    .blue_o   (blue_row)
  );

  lmps_scan_ctrl u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .tick_i     (tick_go),
    .row_o      (scan_row),
    .level_o    (scan_level)
  );

  lmps_row_encode u_encode (
    .red_i         (red_row),
    .green_i       (green_row),
    .blue_i        (blue_row),
    .level_i       (scan_level),
    .word_first_o  (first_d),
    .word_second_o (second_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (item_go) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= tick_go;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q   <= req_type_i;
      index_q <= pixel_index_i;
      color_q <= pixel_color_i;
    end
    if (tick_go) begin
      first_q   <= first_d;
      second_q  <= second_d;
      row_sel_q <= scan_row;
      step_q    <= scan_level;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign driver_word_first_o  = first_q;
  assign driver_word_second_o = second_q;
  assign row_select_o         = row_sel_q;
  assign pwm_step_o           = step_q;

  // a new result beat only comes from a tick that moved on
  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(tick_go))
    else $error("result beat without a tick");

  // the input side only stalls behind a tick blocked by a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && req_q == ReqTick && out_valid_q && out_stall_i))
    else $error("input stalled without cause");

  // the scan row moves only on a tick
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_go |=> $stable(scan_row))
    else $error("row moved without a tick");

  // the level moves only when the row wraps
  a_level_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!tick_go || scan_row != RowW'(RowCount - 1)) |=> $stable(scan_level))
    else $error("level moved without a row wrap");

endmodule

// ----- rtl/lmps_frame_store.sv -----
// Frame store: three colour planes of 8 rows x 8 nibbles, nibble-wide writes.
// One combinational row read for the scan. Depends on lmps_pkg.
module lmps_frame_store import lmps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lmps_wr_t            wr_i,
  input  logic [RowW-1:0]     rd_row_i,
  output logic [RowBitsW-1:0] red_o,
  output logic [RowBitsW-1:0] green_o,
  output logic [RowBitsW-1:0] blue_o
);

  logic [RowBitsW-1:0] red_q   [RowCount];
  logic [RowBitsW-1:0] green_q [RowCount];
  logic [RowBitsW-1:0] blue_q  [RowCount];

  // cleared at reset so the display starts dark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RowCount; r++) begin
        red_q[r]   <= '0;
        green_q[r] <= '0;
        blue_q[r]  <= '0;
      end
    end else if (wr_i.en) begin
      red_q[wr_i.row][wr_i.col*NibW +: NibW]   <= wr_i.red;
      green_q[wr_i.row][wr_i.col*NibW +: NibW] <= wr_i.green;
      blue_q[wr_i.row][wr_i.col*NibW +: NibW]  <= wr_i.blue;
    end
  end

  assign red_o   = red_q[rd_row_i];
  assign green_o = green_q[rd_row_i];
  assign blue_o  = blue_q[rd_row_i];

endmodule

// ----- rtl/lmps_row_encode.sv -----
// Row encoder: 24 nibble compares against the PWM level, then the fixed
// permutation onto the two driver words. Depends on lmps_pkg.
module lmps_row_encode import lmps_pkg::*; (
  input  logic [RowBitsW-1:0] red_i,
  input  logic [RowBitsW-1:0] green_i,
  input  logic [RowBitsW-1:0] blue_i,
  input  logic [LevelW-1:0]   level_i,
  output logic [15:0]         word_first_o,
  output logic [15:0]         word_second_o
);

  logic [OnBitsW-1:0] on_bits;

  // strictly greater: intensity 0 is always dark
  always_comb begin
    for (int c = 0; c < ColCount; c++) begin
      on_bits[3*c]     = red_i[c*NibW +: NibW]   > level_i;
      on_bits[3*c + 1] = green_i[c*NibW +: NibW] > level_i;
      on_bits[3*c + 2] = blue_i[c*NibW +: NibW]  > level_i;
    end
  end

  assign word_first_o  = pack_word(FirstMap, on_bits);
  assign word_second_o = pack_word(SecondMap, on_bits);

endmodule

// ----- rtl/lmps_scan_ctrl.sv -----
// Scan counters (row inner, level outer) and the level count register.
// Depends on lmps_pkg.
module lmps_scan_ctrl import lmps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_data_i,
  input  logic              tick_i,
  output logic [RowW-1:0]   row_o,
  output logic [LevelW-1:0] level_o
);

  logic [LimitW-1:0] limit_q;
  logic [RowW-1:0]   row_q, row_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [LimitW-1:0] limit_eff;
  logic [LimitW-1:0] level_inc;

  always_comb begin
    if (limit_q == '0) begin
      limit_eff = LimitMin;
    end else if (limit_q > LimitMax) begin
      limit_eff = LimitMax;
    end else begin
      limit_eff = limit_q;
    end
  end

  assign level_inc = {1'b0, level_q} + LimitW'(1);

  always_comb begin
    row_d   = row_q;
    level_d = level_q;
    if (tick_i) begin
      row_d = row_q + RowW'(1);
      if (row_q == RowW'(RowCount - 1)) begin
        // limit lowered below the current level takes hold here
        level_d = (level_inc >= limit_eff) ? '0 : level_inc[LevelW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitMax;
      row_q   <= '0;
      level_q <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      row_q   <= row_d;
      level_q <= level_d;
    end
  end

  assign row_o   = row_q;
  assign level_o = level_q;

endmodule

// ----- sim/led_matrix_pwm_row_scanner_test.sv -----
// Self-checking testbench for the LED matrix PWM row scanner.
// Needs lmps_pkg and the scanner RTL; a behavioural scan model predicts each beat.
`timescale 1ns / 100ps

module led_matrix_pwm_row_scanner_test;
  import lmps_pkg::*;

  localparam int unsigned WatchdogLimit = 400;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned ReportCap     = 50;

  typedef struct packed {
    logic [15:0]       word_first;
    logic [15:0]       word_second;
    logic [RowW-1:0]   row;
    logic [LevelW-1:0] level;
  } scan_beat_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              req_type_i    = ReqWrite;
  logic [5:0]        pixel_index_i = '0;
  logic [11:0]       pixel_color_i = '0;
  logic              out_stall_i   = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic [LimitW-1:0] cfg_data_i    = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [15:0]       driver_word_first_o;
  logic [15:0]       driver_word_second_o;
  logic [RowW-1:0]   row_select_o;
  logic [LevelW-1:0] pwm_step_o;
  logic              cfg_ready_o;

  // Scan model state
  logic [11:0]       frame_colour [64];
  logic [RowW-1:0]   scan_row;
  logic [LevelW-1:0] scan_level;
  logic [LimitW-1:0] level_count;
  scan_beat_t        pending_scans [$];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          no_idle     = 1'b0;

  led_matrix_pwm_row_scanner u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .pixel_index_i       (pixel_index_i),
    .pixel_color_i       (pixel_color_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .driver_word_first_o (driver_word_first_o),
    .driver_word_second_o(driver_word_second_o),
    .row_select_o        (row_select_o),
    .pwm_step_o          (pwm_step_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Compare every colour of the current row with the level and place the on bits
  function automatic scan_beat_t scan_current_row();
    logic [7:0]  r_on;
    logic [7:0]  g_on;
    logic [7:0]  b_on;
    logic [11:0] px;
    scan_beat_t  b;
    for (int c = 0; c < 8; c++) begin
      px      = frame_colour[{scan_row, 3'(c)}];
      r_on[c] = px[11:8] > scan_level;
      g_on[c] = px[7:4] > scan_level;
      b_on[c] = px[3:0] > scan_level;
    end
    b.word_first  = {g_on[4], r_on[4], g_on[3], b_on[2], r_on[2], g_on[1], b_on[0], r_on[0],
                     4'b0000, b_on[5], r_on[6], g_on[6], b_on[7]};
    b.word_second = {3'b000, r_on[3], g_on[2], b_on[1], r_on[1], g_on[0], b_on[3], b_on[4],
                     r_on[5], g_on[5], b_on[6], r_on[7], g_on[7], 1'b0};
    b.row         = scan_row;
    b.level       = scan_level;
    return b;
  endfunction

  task automatic apply_request(input logic req, input logic [5:0] idx,
                               input logic [11:0] colour);
    logic [LimitW-1:0] eff;
    logic [LevelW:0]   next_level;
    if (req == ReqWrite) begin
      frame_colour[idx] = colour;
    end else begin
      pending_scans.push_back(scan_current_row());
      if (scan_row == RowW'(RowCount - 1)) begin
        // zero acts as one, anything past sixteen as sixteen
        eff = (level_count < LimitMin) ? LimitMin :
              (level_count > LimitMax) ? LimitMax : level_count;
        next_level = {1'b0, scan_level} + (LevelW+1)'(1);
        scan_level = (next_level >= eff) ? '0 : next_level[LevelW-1:0];
      end
      scan_row = scan_row + RowW'(1);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= ReportCap) begin
      $display("%0t: %s expected %h got %h", $realtime, field, want, got);
    end
  endtask

  task automatic send_item(input logic req, input logic [5:0] idx, input logic [11:0] colour);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    pixel_index_i <= idx;
    pixel_color_i <= colour;
    do @(posedge clk_i); while (in_stall_o);
    apply_request(req, idx, colour);
  endtask

  task automatic random_item(input int unsigned write_pct);
    send_item(($urandom_range(0, 99) < write_pct) ? ReqWrite : ReqTick,
              6'($urandom_range(0, 63)), 12'($urandom_range(0, 4095)));
  endtask

  // Writes carry no result, so give the last one time to land in the frame store
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_level_count(input logic [LimitW-1:0] count);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    level_count = count;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [LimitW-1:0] count, input int unsigned items,
                           input int unsigned write_pct);
    write_level_count(count);
    no_idle = ($urandom_range(0, 3) == 0);
    repeat (items) random_item(write_pct);
  endtask

  // One full row sweep straight after reset: everything dark
  task automatic test_dark_frame();
    no_idle = 1'b1;
    repeat (RowCount) send_item(ReqTick, 6'h3f, 12'hfff);
  endtask

  // Corner pixels, full and single colours, and intensities equal to the level
  task automatic test_pixel_extremes();
    no_idle = 1'b0;
    send_item(ReqWrite, 6'd0, 12'hfff);
    send_item(ReqWrite, 6'd7, 12'hf00);
    send_item(ReqWrite, 6'd56, 12'h0f0);
    send_item(ReqWrite, 6'd63, 12'h00f);
    send_item(ReqWrite, 6'd9, 12'h1e1);
    send_item(ReqWrite, 6'd14, 12'h234);
    repeat (RowCount) send_item(ReqTick, 6'd0, 12'h000);
  endtask

  task automatic test_level_count_settings();
    run_phase(5'd0, 60, 30);
    run_phase(LimitMin, 60, 30);
    run_phase(5'd31, 60, 30);
    run_phase(5'd17, 60, 30);
    run_phase(5'd2, 60, 30);
    run_phase(LimitMax, 60, 30);
    run_phase(5'd15, 60, 30);
  endtask

  // Drop the limit under the running level; it must fall back at the next wrap
  task automatic test_limit_lowered();
    write_level_count(LimitMax);
    no_idle = 1'b0;
    while (scan_level < 4'd9) random_item(10);
    repeat ($urandom_range(0, 7)) send_item(ReqTick, 6'd0, 12'h000);
    run_phase(5'd3, 40, 20);
  endtask

  task automatic test_random_traffic();
    repeat (5) run_phase(5'($urandom_range(0, 31)), 60, $urandom_range(10, 60));
  endtask

  // Receiver: after each beat, unless no_idle is set, hold stall for a random number of cycles
  always @(posedge clk_i) begin : result_stall
    int unsigned hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall_i <= 1'b0;
    end else if (out_valid_o && !out_stall_i && !no_idle) begin
      hold        = $urandom_range(0, 15);
      stall_left  <= hold;
      out_stall_i <= (hold != 0);
    end
  end

  always @(posedge clk_i) begin : result_check
    scan_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_scans.size() == 0) begin
        report_mismatch("beat with no tick pending, row", '0, 32'(row_select_o));
      end else begin
        want = pending_scans.pop_front();
        if (driver_word_first_o !== want.word_first)
          report_mismatch("driver_word_first", 32'(want.word_first), 32'(driver_word_first_o));
        if (driver_word_second_o !== want.word_second)
          report_mismatch("driver_word_second", 32'(want.word_second),
                          32'(driver_word_second_o));
        if (row_select_o !== want.row)
          report_mismatch("row_select", 32'(want.row), 32'(row_select_o));
        if (pwm_step_o !== want.level)
          report_mismatch("pwm_step", 32'(want.level), 32'(pwm_step_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("led_matrix_pwm_row_scanner_test NOT OK");
      $finish;
    end
  end

  initial begin : main_sequence
    for (int i = 0; i < 64; i++) frame_colour[i] = '0;
    scan_row    = '0;
    scan_level  = '0;
    level_count = LimitMax;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_dark_frame();
    test_pixel_extremes();
    test_level_count_settings();
    test_limit_lowered();
    test_random_traffic();
    drain_results();
    if (error_count == 0) begin
      $display("led_matrix_pwm_row_scanner_test OK");
    end else begin
      $display("led_matrix_pwm_row_scanner_test NOT OK");
    end
    $finish;
  end

endmodule
